// File: rtl/tbsc_pkg.sv
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types and constants for the triple buffer slot controller: opcodes,
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tbsc_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int SEQ_W     = 63;
    localparam int LSEQ_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE  = 1'b1;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 5'd3;
    localparam logic [CNT_W-1:0] MIN_SLOTS      = 5'd2;

    typedef enum logic [2:0] {
        OP_RESERVE  = 3'd0,
        OP_PUBLISH  = 3'd1,
        OP_ACQUIRE  = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_READ_SEQ = 3'd4
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic skip;
        logic commit;
    } tbsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_reserve;
        logic cand_ge_n;
        logic cand_free;
        logic last_try;
        logic sync_mode;
        logic out_free;
    } tbsc_stat_t;

endpackage

// File: rtl/tbsc_ctrl.sv
// ----------------------------------------------------------------------------
// tbsc_ctrl
// Sequencer for one item: accept, normalize the first candidate, walk the
// slot ring, apply the held-slot skip and commit the result beat.
// ----------------------------------------------------------------------------
module tbsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tbsc_pkg::tbsc_stat_t stat,
    output tbsc_pkg::tbsc_cmd_t  cmd
);
    import tbsc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_SKIP   = 5'b01000,
        S_WRITE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                priority if (!stat.is_reserve)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.cand_ge_n)
                begin
                    cmd.prep = 1'b1;
                end
                else if (stat.sync_mode)
                begin
                    state_next = S_SKIP;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.cand_free)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    // after a full lap the candidate is back at the first pick
                    cmd.step = 1'b1;
                    if (stat.last_try)
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_SKIP:
            begin
                cmd.skip   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tbsc_dp.sv
// ----------------------------------------------------------------------------
// tbsc_dp
// Slot state, configuration registers, candidate walker and the output
// register of the triple buffer slot controller.
// ----------------------------------------------------------------------------
module tbsc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbsc_pkg::CFG_W-1:0]          cfg_data,
    input  logic [2:0]                          opcode,
    input  logic [tbsc_pkg::SLOT_W-1:0]         slot,
    input  logic signed [tbsc_pkg::LSEQ_W-1:0]  seen_seq,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                slot_valid,
    output logic [tbsc_pkg::SLOT_W-1:0]         slot_out,
    output logic [tbsc_pkg::SEQ_W-1:0]          sequence_res,
    input  tbsc_pkg::tbsc_cmd_t                 cmd,
    output tbsc_pkg::tbsc_stat_t                stat
);
    import tbsc_pkg::*;

    // configuration
    logic [CNT_W-1:0]   slot_count_reg;
    logic               sync_mode_reg;

    // exchange state
    logic [SLOT_W-1:0]  lw_slot_reg, lw_slot_next;
    logic [SLOT_W-1:0]  pub_slot_reg, pub_slot_next;
    logic               pub_valid_reg, pub_valid_next;
    logic [SLOT_W-1:0]  held_slot_reg, held_slot_next;
    logic               held_valid_reg, held_valid_next;
    logic [SEQ_W-1:0]   pub_count_reg, pub_count_next;

    // latched item and walker
    op_t                op_reg;
    logic [SLOT_W-1:0]  slot_in_reg;
    logic [LSEQ_W-1:0]  seen_seq_reg;
    logic [CNT_W-1:0]   cand_reg, cand_next;
    logic [CNT_W-1:0]   tries_reg, tries_next;

    // output beat
    logic               out_valid_reg, out_valid_next;
    logic               slot_valid_reg, slot_valid_next;
    logic [SLOT_W-1:0]  slot_out_reg, slot_out_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;

    logic [CNT_W-1:0]   n_act;
    logic [CNT_W-1:0]   cand_inc;
    logic [CNT_W-1:0]   cand_wrap;
    logic               cand_held;
    logic               cand_pub;
    logic               newer;

    always_comb
    begin
        priority if (slot_count_reg < MIN_SLOTS)
        begin
            n_act = MIN_SLOTS;
        end
        else if (slot_count_reg > CNT_W'(MAX_SLOTS))
        begin
            n_act = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            n_act = slot_count_reg;
        end
    end

    assign cand_inc  = cand_reg + CNT_W'(1);
    assign cand_wrap = (cand_inc == n_act) ? '0 : cand_inc;
    assign cand_held = held_valid_reg && (cand_reg == {1'b0, held_slot_reg});
    assign cand_pub  = pub_valid_reg && (cand_reg == {1'b0, pub_slot_reg});

    // a negative last seen sequence always counts as older
    assign newer = seen_seq_reg[LSEQ_W-1] || ({1'b0, pub_count_reg} > seen_seq_reg);

    assign stat.is_reserve = (op_reg == OP_RESERVE);
    assign stat.cand_ge_n  = (cand_reg >= n_act);
    assign stat.cand_free  = !cand_held && !cand_pub;
    assign stat.last_try   = (tries_reg == (n_act - CNT_W'(1)));
    assign stat.sync_mode  = sync_mode_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        cand_next       = cand_reg;
        tries_next      = tries_reg;
        lw_slot_next    = lw_slot_reg;
        pub_slot_next   = pub_slot_reg;
        pub_valid_next  = pub_valid_reg;
        held_slot_next  = held_slot_reg;
        held_valid_next = held_valid_reg;
        pub_count_next  = pub_count_reg;
        slot_valid_next = slot_valid_reg;
        slot_out_next   = slot_out_reg;
        seq_next        = seq_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        priority if (cmd.load)
        begin
            cand_next  = {1'b0, lw_slot_reg} + CNT_W'(1);
            tries_next = '0;
        end
        else if (cmd.prep)
        begin
            cand_next = cand_reg - n_act;
        end
        else if (cmd.step)
        begin
            cand_next  = cand_wrap;
            tries_next = tries_reg + CNT_W'(1);
        end
        else if (cmd.skip)
        begin
            if (cand_held)
            begin
                cand_next = cand_wrap;
            end
        end
        else if (cmd.commit)
        begin
            out_valid_next  = 1'b1;
            slot_valid_next = 1'b0;
            slot_out_next   = '0;
            unique case (op_reg)
                OP_RESERVE:
                begin
                    lw_slot_next    = cand_reg[SLOT_W-1:0];
                    slot_valid_next = 1'b1;
                    slot_out_next   = cand_reg[SLOT_W-1:0];
                end
                OP_PUBLISH:
                begin
                    pub_slot_next  = slot_in_reg;
                    pub_valid_next = 1'b1;
                    pub_count_next = pub_count_reg + SEQ_W'(1);
                end
                OP_ACQUIRE:
                begin
                    if (pub_valid_reg && (sync_mode_reg || newer))
                    begin
                        held_slot_next  = pub_slot_reg;
                        held_valid_next = 1'b1;
                        slot_valid_next = 1'b1;
                        slot_out_next   = pub_slot_reg;
                        if (sync_mode_reg)
                        begin
                            pub_valid_next = 1'b0;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    held_valid_next = 1'b0;
                end
                default:
                begin
                    // read sequence and unused codes leave state alone
                end
            endcase
            seq_next = pub_count_next;
        end
        else
        begin
            // hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            sync_mode_reg  <= 1'b0;
            lw_slot_reg    <= SLOT_W'(SLOT_COUNT_RST - CNT_W'(1));
            pub_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            pub_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SLOT_COUNT: slot_count_reg <= cfg_data;
                    CFG_SYNC_MODE:  sync_mode_reg  <= cfg_data[0];
                    default:        ;
                endcase
            end
            lw_slot_reg    <= lw_slot_next;
            pub_valid_reg  <= pub_valid_next;
            held_valid_reg <= held_valid_next;
            pub_count_reg  <= pub_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op_t'(opcode);
            slot_in_reg  <= slot;
            seen_seq_reg <= seen_seq;
        end
        cand_reg       <= cand_next;
        tries_reg      <= tries_next;
        pub_slot_reg   <= pub_slot_next;
        held_slot_reg  <= held_slot_next;
        slot_valid_reg <= slot_valid_next;
        slot_out_reg   <= slot_out_next;
        seq_reg        <= seq_next;
    end

    assign out_valid    = out_valid_reg;
    assign slot_valid   = slot_valid_reg;
    assign slot_out     = slot_out_reg;
    assign sequence_res = seq_reg;

endmodule

// File: rtl/triple_buffer_slot_controller.sv
// ----------------------------------------------------------------------------
// triple_buffer_slot_controller
// Slot exchange for one producer and one consumer over a ring of buffers.
// ----------------------------------------------------------------------------
// One item is worked at a time; every item gives one result beat. A reserve
// walks the slot ring one candidate per cycle in the datapath: it first
// brings last written slot plus one below the slot count by repeated
// subtraction, then tests at most as many candidates as the active slot
// count in latest mode before applying the held-slot skip. The result
// register frees the input side as soon as the beat is written, so the next
// item can be taken while the result waits on out_stall. The user must write
// configuration only while no item is in flight; the block itself does not
// enforce this.
module triple_buffer_slot_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbsc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          opcode,
    input  logic [tbsc_pkg::SLOT_W-1:0]         slot,
    input  logic signed [tbsc_pkg::LSEQ_W-1:0]  seen_seq,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                slot_valid,
    output logic [tbsc_pkg::SLOT_W-1:0]         slot_out,
    output logic [tbsc_pkg::SEQ_W-1:0]          sequence_res
);
    import tbsc_pkg::*;

    tbsc_cmd_t  cmd;
    tbsc_stat_t stat;

    tbsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tbsc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .slot         (slot),
        .seen_seq     (seen_seq),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_valid   (slot_valid),
        .slot_out     (slot_out),
        .sequence_res (sequence_res),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef SYNTH
    // a result is never written over a beat that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("result written over a stalled beat");

    // a new result beat only appears after a commit
    a_beat_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result beat without commit");

    // a reserved slot always lies inside the active ring
    a_reserve_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && stat.is_reserve) |-> !stat.cand_ge_n)
        else $error("reserved slot beyond slot count");
`endif

endmodule
